// File: hdl/fir_pkg.sv
// Shared types and constants for the loadable-tap FIR filter.
package fir_pkg;

	localparam int DATA_W = 16;
	localparam int IDX_W  = 6;
	localparam int GAIN_W = 8;
	localparam int PROD_W = 2 * DATA_W;

	// op field codes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// per-cell control: move data one cell along the rings, or write a tap
	typedef struct packed {
		logic shift_hist;
		logic shift_coef;
		logic load_coef;
	} fir_cell_ctl_t;

endpackage

// File: hdl/fir_cell.sv
// One tap cell: holds one history sample and one coefficient.
module fir_cell #(
	parameter logic signed [15:0] RST_COEF = 16'sd0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  fir_pkg::fir_cell_ctl_t                  ctl,
	input  logic signed [fir_pkg::DATA_W-1:0]       hist_in,
	input  logic signed [fir_pkg::DATA_W-1:0]       coef_in,
	input  logic signed [fir_pkg::DATA_W-1:0]       coef_wdata,
	output logic signed [fir_pkg::DATA_W-1:0]       hist_q,
	output logic signed [fir_pkg::DATA_W-1:0]       coef_q
);
	import fir_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.shift_hist) begin
			hist_q <= hist_in;
		end
	end

	// tap write only happens while the rings are at rest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= RST_COEF;
		end else if (ctl.load_coef) begin
			coef_q <= coef_wdata;
		end else if (ctl.shift_coef) begin
			coef_q <= coef_in;
		end
	end

endmodule

// File: hdl/fir_mac.sv
// Multiply-accumulate at the end of the tap chain, with rounding and saturation.
module fir_mac #(
	parameter int TAPS           = 51,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                clear,
	input  logic                                en,
	input  logic signed [fir_pkg::DATA_W-1:0]   hist,
	input  logic signed [fir_pkg::DATA_W-1:0]   coef,
	output logic signed [fir_pkg::DATA_W-1:0]   result,
	output logic                                ovf
);
	import fir_pkg::*;

	localparam int ACC_W = PROD_W + 2 + $clog2(TAPS + 1);
	localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -(ACC_W'(32768));

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  rnd;
	logic signed [ACC_W-1:0]  shifted;

	always_ff @(posedge clk) begin
		prod_s1 <= hist * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= en;
			if (clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	// round half up: floor((acc + half) / 2^frac)
	assign rnd     = acc_q + HALF;
	assign shifted = rnd >>> COEF_FRAC_BITS;

	always_comb begin
		if (shifted > SAT_MAX) begin
			result = 16'sh7fff;
			ovf    = 1'b1;
		end else if (shifted < SAT_MIN) begin
			result = -16'sh8000;
			ovf    = 1'b1;
		end else begin
			result = shifted[DATA_W-1:0];
			ovf    = 1'b0;
		end
	end

endmodule

// File: hdl/fir_filter_loadable_taps.sv
// Top level of the loadable-tap FIR filter: tap cell chain, MAC and control.
//
//   channel   signals                                      direction
//   input     in_valid/in_ready, op, sample,                in
//             coef_index, coef_value
//   output    out_valid/out_ready, filtered, overflow       out
//   config    cfg_we, cfg_wdata (gain)                      in
//
// A sample transfer holds off the next input transfer while the
// history and coefficient rings rotate once through all TAPS cells past one
// multiplier, then the DRAIN state empties the product register and the FINISH
// state loads the output register. A coefficient-write transfer leaves the block idle.
// Reset clears the history, loads a unit impulse into the taps and sets gain 1.
// A result held in the output register does not stall input; only loading a
// new result waits for the previous one to be taken.
module fir_filter_loadable_taps #(
	parameter int TAPS           = 51,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                op,
	input  logic signed [fir_pkg::DATA_W-1:0]   sample,
	input  logic [fir_pkg::IDX_W-1:0]           coef_index,
	input  logic signed [fir_pkg::DATA_W-1:0]   coef_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [fir_pkg::DATA_W-1:0]   filtered,
	output logic                                overflow,
	input  logic                                cfg_we,
	input  logic [fir_pkg::GAIN_W-1:0]          cfg_wdata
);
	import fir_pkg::*;

	localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);
	// 1.0 in Q(16-F).F, clipped to the largest 16-bit value
	localparam int ONE_RAW = (COEF_FRAC_BITS >= 15) ? 32767 : (1 << COEF_FRAC_BITS);
	localparam logic signed [DATA_W-1:0] ONE_COEF = DATA_W'(ONE_RAW);
	localparam int GPROD_W = DATA_W + GAIN_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [GAIN_W-1:0]    gain_q;
	logic                 out_valid_q;
	logic signed [DATA_W-1:0] filtered_q;
	logic                 overflow_q;

	logic                 in_xfer;
	logic                 smp_xfer;
	logic                 coef_xfer;
	logic                 rotate;
	logic signed [GPROD_W-1:0] gprod;
	logic signed [DATA_W-1:0]  gained;
	logic signed [DATA_W-1:0]  hist_w [TAPS];
	logic signed [DATA_W-1:0]  coef_w [TAPS];
	logic signed [DATA_W-1:0]  hist_head;
	logic signed [DATA_W-1:0]  mac_result;
	logic                      mac_ovf;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign smp_xfer  = in_xfer && (op == OP_SAMPLE);
	assign coef_xfer = in_xfer && (op == OP_COEF);
	assign rotate    = (state_q == ST_RUN);

	// apply gain and clip to 16 bits before the sample enters the history
	assign gprod = sample * $signed({1'b0, gain_q});
	always_comb begin
		if (gprod > GPROD_W'(32767)) begin
			gained = 16'sh7fff;
		end else if (gprod < -(GPROD_W'(32768))) begin
			gained = -16'sh8000;
		end else begin
			gained = gprod[DATA_W-1:0];
		end
	end

	// cell 0 takes the new sample on insert, the last cell's entry on rotate
	assign hist_head = smp_xfer ? gained : hist_w[TAPS-1];

	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		fir_cell_ctl_t ctl;
		logic signed [DATA_W-1:0] hist_src;
		logic signed [DATA_W-1:0] coef_src;

		assign ctl.shift_hist = smp_xfer || rotate;
		assign ctl.shift_coef = rotate;
		assign ctl.load_coef  = coef_xfer && ({2'b00, coef_index} == 8'(i));

		if (i == 0) begin : g_head
			assign hist_src = hist_head;
			assign coef_src = coef_w[TAPS-1];
		end else begin : g_body
			assign hist_src = hist_w[i-1];
			assign coef_src = coef_w[i-1];
		end

		fir_cell #(
			.RST_COEF((i == 0) ? ONE_COEF : 16'sd0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.hist_in    (hist_src),
			.coef_in    (coef_src),
			.coef_wdata (coef_value),
			.hist_q     (hist_w[i]),
			.coef_q     (coef_w[i])
		);
	end

	fir_mac #(
		.TAPS           (TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (smp_xfer),
		.en     (rotate),
		.hist   (hist_w[TAPS-1]),
		.coef   (coef_w[TAPS-1]),
		.result (mac_result),
		.ovf    (mac_ovf)
	);

	// gain register: the user must write it only while the filter is at rest; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_W'(1);
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			filtered_q  <= '0;
			overflow_q  <= 1'b0;
		end else begin
			// drop the held result once the consumer takes it
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (smp_xfer) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					// advance the rings one cell; stop after a full turn
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					// hold the sum until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						filtered_q  <= mac_result;
						overflow_q  <= mac_ovf;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign overflow  = overflow_q;

`ifndef NO_ASSERTIONS
	a_sample_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		smp_xfer |=> (state_q == ST_RUN))
		else $error("sample transfer did not start the tap rotation");

	a_coef_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		coef_xfer |=> (state_q == ST_IDLE))
		else $error("coefficient write left the idle state");

	a_full_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> ($past(cnt_q) == CNT_LAST))
		else $error("rings left before a full turn");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_FINISH))
		else $error("result appeared outside the finish step");
`endif

endmodule

// File: bench/tb_fir_filter_loadable_taps.sv
// Self-checking bench for the loadable-tap FIR filter: directed table, then random gain phases.
`timescale 1ns / 100ps

module tb_fir_filter_loadable_taps;
	import fir_pkg::*;

	localparam int TAPS           = 51;
	localparam int COEF_FRAC_BITS = 14;
	localparam int MAX_WAIT       = 18;
	// settle time, longer than a sample transfer occupies the block
	localparam int SETTLE_CYC     = TAPS + 8;
	localparam int HOLD_CYC       = 400;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 173;

	typedef struct packed {
		logic signed [DATA_W-1:0] filtered;
		logic                     overflow;
	} fir_result_t;

	// one row of the directed table; typed rows carry their own expected result
	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] sample;
		logic [IDX_W-1:0]         coef_index;
		logic signed [DATA_W-1:0] coef_value;
		logic                     typed;
		fir_result_t              result;
	} dir_row_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_ready;
	logic                     op         = OP_SAMPLE;
	logic signed [DATA_W-1:0] sample     = '0;
	logic [IDX_W-1:0]         coef_index = '0;
	logic signed [DATA_W-1:0] coef_value = '0;
	logic                     out_valid;
	logic                     out_ready  = 1'b0;
	logic signed [DATA_W-1:0] filtered;
	logic                     overflow;
	logic                     cfg_we     = 1'b0;
	logic [GAIN_W-1:0]        cfg_wdata  = '0;

	// shadow of the filter state, kept in step with accepted transfers
	logic [GAIN_W-1:0]        gain_q;
	logic signed [DATA_W-1:0] hist_q [TAPS];
	logic signed [DATA_W-1:0] taps_q [TAPS];

	fir_result_t pending_outputs [$];
	dir_row_t    dir_tab [$];

	bit send_burst = 1'b0;
	bit rcv_burst  = 1'b0;
	bit hold_req   = 1'b0;

	int err_cnt     = 0;
	int n_samples   = 0;
	int n_coef      = 0;
	int n_ignored   = 0;
	int n_results   = 0;
	int n_ovf       = 0;
	int n_clipped   = 0;
	int n_gains     = 1;

	fir_filter_loadable_taps #(
		.TAPS           (TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered   (filtered),
		.overflow   (overflow),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop in case a handshake never completes
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic dir_row_t row(input int o, input int s, input int ix, input int cv,
		input bit typed, input int f, input bit ov);
		dir_row_t r;
		r.op              = o[0];
		r.sample          = s[DATA_W-1:0];
		r.coef_index      = ix[IDX_W-1:0];
		r.coef_value      = cv[DATA_W-1:0];
		r.typed           = typed;
		r.result.filtered = f[DATA_W-1:0];
		r.result.overflow = ov;
		return r;
	endfunction

	// Apply gain and clip, shift into the history, form the dot product with the
	// taps, round half up (floor of sum + 0.5 LSB) and clip to 16 bits.
	function automatic fir_result_t filter_sample(input logic signed [DATA_W-1:0] s);
		fir_result_t r;
		int          prod;
		longint      acc;
		longint      y;
		int          k;
		prod = int'(s) * int'(gain_q);
		if (prod > 32767) begin
			prod = 32767;
			n_clipped++;
		end else if (prod < -32768) begin
			prod = -32768;
			n_clipped++;
		end
		for (k = TAPS - 1; k > 0; k--)
			hist_q[k] = hist_q[k - 1];
		hist_q[0] = prod[DATA_W-1:0];
		acc = 0;
		for (k = 0; k < TAPS; k++)
			acc += longint'(hist_q[k]) * longint'(taps_q[k]);
		acc += longint'(1) << (COEF_FRAC_BITS - 1);
		y = acc >>> COEF_FRAC_BITS;
		r.overflow = 1'b0;
		if (y > 32767) begin
			y = 32767;
			r.overflow = 1'b1;
		end else if (y < -32768) begin
			y = -32768;
			r.overflow = 1'b1;
		end
		r.filtered = y[DATA_W-1:0];
		return r;
	endfunction

	// Offer one item after a random gap and hold it until the transfer; then
	// advance the shadow state. A typed row pushes its own expected result.
	task automatic put_item(input logic o, input logic signed [DATA_W-1:0] s,
		input logic [IDX_W-1:0] ix, input logic signed [DATA_W-1:0] cv,
		input bit typed, input fir_result_t tres);
		int          gap;
		fir_result_t r;
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		sample     <= s;
		coef_index <= ix;
		coef_value <= cv;
		do @(posedge clk); while (!in_ready);
		if (o == OP_COEF) begin
			n_coef++;
			if (ix < TAPS)
				taps_q[ix] = cv;
			else
				n_ignored++;
		end else begin
			r = filter_sample(s);
			pending_outputs.push_back(typed ? tres : r);
			n_samples++;
		end
	endtask

	// Mostly samples; some tap writes, a few aimed past the last tap.
	task automatic random_item();
		logic [IDX_W-1:0]         ix;
		logic signed [DATA_W-1:0] v;
		int                       kind;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < 12) begin
			if ($urandom_range(0, 9) == 0)
				ix = IDX_W'($urandom_range(TAPS, 63));
			else
				ix = IDX_W'($urandom_range(0, TAPS - 1));
			if (kind == 0)
				v = 16'sh7fff;
			else if (kind == 1)
				v = 16'sh8000;
			else if (kind < 7)
				v = DATA_W'($urandom_range(0, 4095) - 2048);
			else
				v = DATA_W'($urandom());
			put_item(OP_COEF, DATA_W'($urandom()), ix, v, 1'b0, '0);
		end else begin
			if (kind == 0)
				v = 16'sh7fff;
			else if (kind == 1)
				v = 16'sh8000;
			else if (kind < 5)
				v = DATA_W'($urandom_range(0, 511) - 256);
			else
				v = DATA_W'($urandom());
			put_item(OP_SAMPLE, v, IDX_W'($urandom()), DATA_W'($urandom()), 1'b0, '0);
		end
	endtask

	// Drop valid and hold until every expected result is in, then let the
	// block finish any tap write still in flight.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_gain(input logic [GAIN_W-1:0] g);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we    <= 1'b0;
		gain_q     = g;
		n_gains++;
	endtask

	// Receiver: stall at random before each result, or for a long stretch on request.
	initial begin
		int          stall;
		fir_result_t want;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end
			stall = draw_wait(rcv_burst);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			n_results++;
			if (overflow)
				n_ovf++;
			if (pending_outputs.size() == 0) begin
				report_mismatch($sformatf("result %0d: filtered %0d overflow %0b with nothing pending",
					n_results, filtered, overflow));
			end else begin
				want = pending_outputs.pop_front();
				if (filtered !== want.filtered)
					report_mismatch($sformatf("result %0d: filtered %0d, want %0d",
						n_results, filtered, want.filtered));
				if (overflow !== want.overflow)
					report_mismatch($sformatf("result %0d: overflow %0b, want %0b",
						n_results, overflow, want.overflow));
			end
		end
	end

	// Main sequence: reset, directed table, then random phases at several gains.
	initial begin
		int               k;
		int               ph;
		logic [GAIN_W-1:0] g;

		// state after reset: gain 1, empty history, unit impulse at tap 0
		gain_q = GAIN_W'(1);
		for (k = 0; k < TAPS; k++) begin
			hist_q[k] = '0;
			taps_q[k] = '0;
		end
		taps_q[0] = 16'sd16384;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit impulse passes samples straight through, extremes included
		dir_tab.push_back(row(OP_SAMPLE,  32767, 0, 0, 1'b1,  32767, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE, -32768, 0, 0, 1'b1, -32768, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,      0, 0, 0, 1'b1,      0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,      1, 0, 0, 1'b1,      1, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,     -1, 0, 0, 1'b1,     -1, 1'b0));
		// tap 0 at one half: halves round up, for negative sums too
		dir_tab.push_back(row(OP_COEF,        0, 0, 8192, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,     -1, 0, 0, 1'b1,      0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,     -3, 0, 0, 1'b1,     -1, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,      1, 0, 0, 1'b1,      1, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE, -32768, 0, 0, 1'b1, -16384, 1'b0));
		// extreme taps, and writes past the last tap that must be ignored
		dir_tab.push_back(row(OP_COEF,        0,  1,  32767, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_COEF,        0, 50, -32768, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_COEF,        0, 51,   1234, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_COEF,        0, 63,     -1, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_COEF,        0,  0, -32768, 1'b0, 0, 1'b0));
		// drive the sum into both rails
		dir_tab.push_back(row(OP_SAMPLE,  32767, 0, 0, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,  32767, 0, 0, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE, -32768, 0, 0, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,  12345, 0, 0, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE, -32768, 0, 0, 1'b0, 0, 1'b0));
		dir_tab.push_back(row(OP_SAMPLE,  32767, 0, 0, 1'b0, 0, 1'b0));

		foreach (dir_tab[k])
			put_item(dir_tab[k].op, dir_tab[k].sample, dir_tab[k].coef_index,
				dir_tab[k].coef_value, dir_tab[k].typed, dir_tab[k].result);

		for (ph = 0; ph < PHASES; ph++) begin
			// full scale, zero gain, unity, then a spread of others
			case (ph)
				0: g = 8'd255;
				1: g = 8'd0;
				2: g = 8'd1;
				3: g = 8'd2;
				4: g = 8'd128;
				default: g = GAIN_W'($urandom_range(1, 255));
			endcase
			set_gain(g);
			send_burst = (ph % 3 == 1) || (ph == 5) || (ph == 2);
			rcv_burst  = (ph % 4 == 3) || (ph == 5);
			// stall the output for a long stretch while the sender keeps offering
			if (ph == 2)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) random_item();
		end

		wait_drained();

		$display("run: %0d samples, %0d tap writes (%0d past the last tap), %0d results checked",
			n_samples, n_coef, n_ignored, n_results);
		$display("run: %0d gain settings, %0d gained samples clipped, %0d saturated outputs",
			n_gains, n_clipped, n_ovf);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
